// ===== src/hsi_pkg.sv =====
// package for the heap sort core: payload structs and sizing constants
// no dependencies
`default_nettype none
package hsi_pkg;
	localparam int MAX_ENTRIES_DEF = 64;
	localparam int KEY_W = 32;
	localparam int POS_W = 7;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic                    last_item;
	} in_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] sorted_key;
		logic [POS_W-1:0]        original_position;
		logic                    last_result;
		logic                    overflowed;
	} out_item_t;
endpackage
`default_nettype wire

// ===== src/hsi_store.sv =====
// key and position memory with one write port and one registered read port
// depends on hsi_pkg
`default_nettype none
module hsi_store #(
	parameter int DEPTH = hsi_pkg::MAX_ENTRIES_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [AW-1:0]                waddr,
	input  wire logic [hsi_pkg::KEY_W-1:0]    wkey,
	input  wire logic [hsi_pkg::POS_W-1:0]    wpos,
	input  wire logic [AW-1:0]                raddr,
	output logic      [hsi_pkg::KEY_W-1:0]    rkey,
	output logic      [hsi_pkg::POS_W-1:0]    rpos
);
	import hsi_pkg::*;
	logic [KEY_W+POS_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= {wkey, wpos};
		{rkey, rpos} <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== src/heap_sort_with_index_core.sv =====
// heap sort core: load, in-memory heapsort sequencer with one compare unit, emit
// depends on hsi_pkg and hsi_store
//
// channel | direction | handshake          | payload
// cmd     | in        | start & !busy      | cmd (in_item_t)
// result  | out       | res_valid, 1 cycle | res (out_item_t)
//
// a non-last item is stored while idle and the core stays ready for the next; on
// the last item the heapsort runs in the memory, each sift step up to two child
// reads, a compare and a move, then the N results are emitted, each read then shown.
// reset clears the item count, overflow flag, result valid and sequencer; memory contents are not cleared.
// results cannot be stalled; busy stays high until the last result is shown.
`default_nettype none
module heap_sort_with_index_core #(
	parameter int MAX_ENTRIES = hsi_pkg::MAX_ENTRIES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire hsi_pkg::in_item_t  cmd,
	output logic                    busy,
	output logic                    res_valid,
	output hsi_pkg::out_item_t      res
);
	import hsi_pkg::*;
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1) + 1;

	localparam logic [3:0] S_IDLE = 4'd0, S_NEXT = 4'd1, S_RDC = 4'd2,
		S_RDJ = 4'd3, S_RDJ1 = 4'd4, S_CMP = 4'd5, S_PUT = 4'd6,
		S_EXA = 4'd7, S_EXB = 4'd8, S_EXC = 4'd9, S_EMA = 4'd10, S_EMB = 4'd11,
		S_RDW = 4'd12;
	logic [3:0] state_q;

	logic [CW-1:0] cnt_q, half_q, lastpos_q, i_q, j_q, e_q;
	logic ovf_q;
	logic signed [KEY_W-1:0] ck_q, kj_q;
	logic [POS_W-1:0] cp_q, pj_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [KEY_W-1:0] wkey, rkey;
	logic [POS_W-1:0] wpos, rpos;
	logic [CW-1:0] rsel;

	hsi_store #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_store (
		.clk, .we, .waddr, .wkey, .wpos, .raddr, .rkey, .rpos);

	// heap index is 1-based; memory address is index-1
	always_comb begin
		rsel = i_q;
		unique case (state_q)
			S_NEXT: rsel = (half_q > 1) ? half_q - 1'b1 : lastpos_q;
			S_RDC: rsel = j_q;
			S_RDJ: rsel = j_q + 1'b1;
			S_EXA: rsel = CW'(1);
			S_EMA: rsel = e_q;
			default: rsel = i_q;
		endcase
	end
	assign raddr = AW'(rsel - 1'b1);

	logic [CW-1:0] wsel;
	always_comb begin
		we = 1'b0;
		wsel = i_q;
		wkey = ck_q;
		wpos = cp_q;
		unique case (state_q)
			S_IDLE: begin
				we = start && (cnt_q < CW'(MAX_ENTRIES));
				wsel = cnt_q + 1'b1;
				wkey = cmd.key;
				wpos = POS_W'(cnt_q + 1'b1);
			end
			S_EXB: begin
				we = 1'b1; wsel = lastpos_q; wkey = rkey; wpos = rpos;
			end
			S_CMP: begin
				we = (ck_q < kj_q); wkey = kj_q; wpos = pj_q;
			end
			S_PUT: we = 1'b1;
			default: ;
		endcase
	end
	assign waddr = AW'(wsel - 1'b1);

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					logic [CW-1:0] n;
					n = (cnt_q < CW'(MAX_ENTRIES)) ? cnt_q + 1'b1 : cnt_q;
					if (cnt_q < CW'(MAX_ENTRIES)) cnt_q <= n;
					else ovf_q <= 1'b1;
					if (cmd.last_item) begin
						half_q <= (n >> 1) + 1'b1;
						lastpos_q <= n;
						e_q <= CW'(1);
						state_q <= (n >= 2) ? S_NEXT : S_EMA;
					end
				end
				S_NEXT: begin
					if (half_q > 1) begin
						half_q <= half_q - 1'b1;
						i_q <= half_q - 1'b1;
						j_q <= (half_q - 1'b1) << 1;
						state_q <= S_RDW;
					end else state_q <= S_EXA;
				end
				S_RDW: begin
					ck_q <= rkey; cp_q <= rpos;
					state_q <= (j_q <= lastpos_q) ? S_RDC : S_PUT;
				end
				S_EXA: begin
					// memory holds entry lastpos from S_NEXT read; grab it
					ck_q <= rkey; cp_q <= rpos;
					state_q <= S_EXB;
				end
				S_EXB: begin
					// rkey now holds k[1], written to lastpos
					lastpos_q <= lastpos_q - 1'b1;
					i_q <= CW'(1);
					j_q <= CW'(2);
					if (lastpos_q - 1'b1 == 1) state_q <= S_PUT;
					else state_q <= (CW'(2) <= lastpos_q - 1'b1) ? S_RDC : S_PUT;
				end
				S_RDC: state_q <= S_RDJ;
				S_RDJ: begin
					kj_q <= rkey; pj_q <= rpos;
					state_q <= (j_q < lastpos_q) ? S_RDJ1 : S_CMP;
				end
				S_RDJ1: begin
					if ($signed(kj_q) < $signed(rkey)) begin
						kj_q <= rkey; pj_q <= rpos; j_q <= j_q + 1'b1;
					end
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (ck_q < kj_q) begin
						i_q <= j_q;
						j_q <= j_q << 1;
						state_q <= ((j_q << 1) <= lastpos_q) ? S_RDC : S_PUT;
					end else state_q <= S_PUT;
				end
				S_PUT: state_q <= (lastpos_q == 1) ? S_EMA : S_NEXT;
				S_EMA: state_q <= S_EMB;
				S_EMB: begin
					res_valid <= 1'b1;
					res.sorted_key <= rkey;
					res.original_position <= rpos;
					res.last_result <= (e_q == cnt_q);
					res.overflowed <= ovf_q;
					e_q <= e_q + 1'b1;
					if (e_q == cnt_q) begin
						cnt_q <= '0; ovf_q <= 1'b0; state_q <= S_IDLE;
					end else state_q <= S_EMA;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result only appears after the sequencer left idle
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last_result |-> busy) else $error("result while idle");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_result |-> !busy) else $error("not idle after last");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ENTRIES)) else $error("count beyond capacity");
endmodule
`default_nettype wire
